// ===== rtl/command_tag_allocator_with_backlog_core_macros.svh =====
// Assertion macros used by the allocator RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef COMMAND_TAG_ALLOCATOR_WITH_BACKLOG_CORE_MACROS_SVH
`define COMMAND_TAG_ALLOCATOR_WITH_BACKLOG_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ctab_pkg.sv =====
package ctab_pkg;

    localparam int MAX_TAGS      = 64;
    localparam int BACKLOG_DEPTH = 64;
    localparam int HANDLE_BITS   = 16;

    localparam int TAG_W    = $clog2(MAX_TAGS);
    localparam int TCNT_W   = $clog2(MAX_TAGS + 1);
    localparam int BL_W     = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
    localparam int BLCNT_W  = $clog2(BACKLOG_DEPTH + 1);
    localparam int HANDLE_W = HANDLE_BITS;
    localparam int CTAG_W   = 16;
    localparam int KIND_W   = 3;

    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [TCNT_W-1:0]   tcnt_t;
    typedef logic [BL_W-1:0]     bl_idx_t;
    typedef logic [BLCNT_W-1:0]  bl_cnt_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    typedef enum logic [0:0] {
        REQ_SUBMIT     = 1'b0,
        REQ_COMPLETION = 1'b1
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH = 3'd0,
        KIND_QUEUED   = 3'd1,
        KIND_COMPLETE = 3'd2,
        KIND_RANGE    = 3'd3,
        KIND_INACTIVE = 3'd4,
        KIND_FULL     = 3'd5
    } kind_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        kind_t   kind;
        tag_t    tag;
        handle_t handle;
        logic    last;
    } res_t;

    // Up to two results pushed into the output buffer in one cycle
    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

    typedef struct packed {
        logic re;
        tag_t raddr;
        logic we;
        tag_t waddr;
        tag_t wdata;
    } free_mem_req_t;

    typedef struct packed {
        logic    re;
        tag_t    raddr;
        logic    we;
        tag_t    waddr;
        handle_t wdata;
    } act_mem_req_t;

    typedef struct packed {
        logic    re;
        bl_idx_t raddr;
        logic    we;
        bl_idx_t waddr;
        handle_t wdata;
    } bl_mem_req_t;

    // Circular position head + cnt over MAX_TAGS entries
    function automatic tag_t free_pos(tag_t head, tcnt_t cnt);
        logic [TCNT_W:0] sum;
        sum = (TCNT_W + 1)'(head) + (TCNT_W + 1)'(cnt);
        if (sum >= (TCNT_W + 1)'(MAX_TAGS)) begin
            sum = sum - (TCNT_W + 1)'(MAX_TAGS);
        end
        return sum[TAG_W-1:0];
    endfunction

    // Circular position head + cnt over BACKLOG_DEPTH entries
    function automatic bl_idx_t bl_pos(bl_idx_t head, bl_cnt_t cnt);
        logic [BLCNT_W:0] sum;
        sum = (BLCNT_W + 1)'(head) + (BLCNT_W + 1)'(cnt);
        if (sum >= (BLCNT_W + 1)'(BACKLOG_DEPTH)) begin
            sum = sum - (BLCNT_W + 1)'(BACKLOG_DEPTH);
        end
        return sum[BL_W-1:0];
    endfunction

endpackage

// ===== rtl/ctab_ram.sv =====
module ctab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ctab_obuf.sv =====
module ctab_obuf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctab_pkg::push_t            push,
    output logic [1:0]                 space,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ctab_pkg::KIND_W-1:0] result_kind,
    output logic [ctab_pkg::TAG_W-1:0]  result_tag,
    output logic [ctab_pkg::HANDLE_W-1:0] result_handle,
    output logic                       last
);

    import ctab_pkg::*;

    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop = (count_reg != 2'd0) && !out_stall;

    // Free slots this cycle, counting the item leaving now
    assign space = 2'd2 - count_reg + {1'b0, pop};

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_next - 2'd1;
        end
        if (push.v0)
        begin
            if (count_next == 2'd0)
            begin
                slot0_next = push.r0;
            end
            else
            begin
                slot1_next = push.r0;
            end
            count_next = count_next + 2'd1;
        end
        if (push.v1)
        begin
            slot1_next = push.r1;
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid     = (count_reg != 2'd0);
    assign result_kind   = slot0_reg.kind;
    assign result_tag    = slot0_reg.tag;
    assign result_handle = slot0_reg.handle;
    assign last          = slot0_reg.last;

endmodule

// ===== rtl/ctab_ctrl.sv =====
module ctab_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [ctab_pkg::HANDLE_W-1:0] request_handle,
    input  logic [ctab_pkg::CTAG_W-1:0]   completion_tag,
    input  logic                          cfg_wr_en,
    input  logic [ctab_pkg::TCNT_W-1:0]   cfg_wr_data,
    output ctab_pkg::free_mem_req_t       free_req,
    input  logic [ctab_pkg::TAG_W-1:0]    free_rdata,
    output ctab_pkg::act_mem_req_t        act_req,
    input  logic [ctab_pkg::HANDLE_W-1:0] act_rdata,
    output ctab_pkg::bl_mem_req_t         bl_req,
    input  logic [ctab_pkg::HANDLE_W-1:0] bl_rdata,
    input  logic [1:0]                    space,
    output ctab_pkg::push_t               push
);

    import ctab_pkg::*;

    state_t              state_reg, state_next;
    tcnt_t               tcnt_reg, tcnt_next;
    tag_t                free_head_reg, free_head_next;
    tcnt_t               free_cnt_reg, free_cnt_next;
    bl_idx_t             bl_head_reg, bl_head_next;
    bl_cnt_t             bl_cnt_reg, bl_cnt_next;
    logic [MAX_TAGS-1:0] active_reg, active_next;
    logic [MAX_TAGS-1:0] written_reg, written_next;

    logic                type_reg;
    handle_t             handle_reg;
    logic [CTAG_W-1:0]   ctag_reg;

    logic                accept;
    tag_t                ctag_idx;
    logic                range_err;
    logic                act_hit;
    logic                pair;
    logic [1:0]          need;
    tag_t                pop_tag;
    tcnt_t               cfg_val;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign ctag_idx  = ctag_reg[TAG_W-1:0];
    assign range_err = (ctag_reg >= CTAG_W'(tcnt_reg));
    assign act_hit   = !range_err && active_reg[ctag_idx];
    assign pair      = (type_reg == REQ_COMPLETION) && act_hit && (bl_cnt_reg != '0);
    assign need      = pair ? 2'd2 : 2'd1;
    // Entries never written since reinit still hold their own index
    assign pop_tag   = written_reg[free_head_reg] ? free_rdata : free_head_reg;

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_val = tcnt_t'(1);
        end
        else if (cfg_wr_data > tcnt_t'(MAX_TAGS))
        begin
            cfg_val = tcnt_t'(MAX_TAGS);
        end
        else
        begin
            cfg_val = cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tcnt_next      = tcnt_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        bl_head_next   = bl_head_reg;
        bl_cnt_next    = bl_cnt_reg;
        active_next    = active_reg;
        written_next   = written_reg;
        push           = '0;
        in_stall       = (state_reg != ST_IDLE);

        free_req       = '0;
        free_req.re    = accept;
        free_req.raddr = free_head_reg;
        act_req        = '0;
        act_req.re     = accept;
        act_req.raddr  = completion_tag[TAG_W-1:0];
        bl_req         = '0;
        bl_req.re      = accept;
        bl_req.raddr   = bl_head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (space >= need)
                begin
                    state_next = ST_IDLE;
                    push.v0    = 1'b1;
                    push.r0    = '{kind: KIND_FULL, tag: '0, handle: '0, last: 1'b1};
                    if (type_reg == REQ_SUBMIT)
                    begin
                        if (free_cnt_reg != '0)
                        begin
                            free_head_next       = free_pos(free_head_reg, tcnt_t'(1));
                            free_cnt_next        = free_cnt_reg - tcnt_t'(1);
                            active_next[pop_tag] = 1'b1;
                            act_req.we           = 1'b1;
                            act_req.waddr        = pop_tag;
                            act_req.wdata        = handle_reg;
                            push.r0.kind         = KIND_DISPATCH;
                            push.r0.tag          = pop_tag;
                            push.r0.handle       = handle_reg;
                        end
                        else if (bl_cnt_reg < bl_cnt_t'(BACKLOG_DEPTH))
                        begin
                            bl_req.we      = 1'b1;
                            bl_req.waddr   = bl_pos(bl_head_reg, bl_cnt_reg);
                            bl_req.wdata   = handle_reg;
                            bl_cnt_next    = bl_cnt_reg + bl_cnt_t'(1);
                            push.r0.kind   = KIND_QUEUED;
                            push.r0.handle = handle_reg;
                        end
                    end
                    else if (range_err)
                    begin
                        push.r0.kind = KIND_RANGE;
                    end
                    else if (!act_hit)
                    begin
                        push.r0.kind = KIND_INACTIVE;
                    end
                    else if (pair)
                    begin
                        // Hand the tag straight to the oldest backlog item
                        bl_head_next  = bl_pos(bl_head_reg, bl_cnt_t'(1));
                        bl_cnt_next   = bl_cnt_reg - bl_cnt_t'(1);
                        act_req.we    = 1'b1;
                        act_req.waddr = ctag_idx;
                        act_req.wdata = bl_rdata;
                        push.r0       = '{kind: KIND_DISPATCH, tag: ctag_idx,
                                          handle: bl_rdata, last: 1'b0};
                        push.v1       = 1'b1;
                        push.r1       = '{kind: KIND_COMPLETE, tag: ctag_idx,
                                          handle: act_rdata, last: 1'b1};
                    end
                    else
                    begin
                        active_next[ctag_idx] = 1'b0;
                        if (free_cnt_reg < tcnt_t'(MAX_TAGS))
                        begin
                            free_req.we    = 1'b1;
                            free_req.waddr = free_pos(free_head_reg, free_cnt_reg);
                            free_req.wdata = ctag_idx;
                            written_next[free_req.waddr] = 1'b1;
                            free_cnt_next  = free_cnt_reg + tcnt_t'(1);
                        end
                        push.r0 = '{kind: KIND_COMPLETE, tag: ctag_idx,
                                    handle: act_rdata, last: 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Reinitialize the tag count, free list, backlog and active tags on a register write
        if (cfg_wr_en)
        begin
            tcnt_next      = cfg_val;
            free_head_next = '0;
            free_cnt_next  = cfg_val;
            bl_head_next   = '0;
            bl_cnt_next    = '0;
            active_next    = '0;
            written_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tcnt_reg      <= tcnt_t'(MAX_TAGS);
            free_head_reg <= '0;
            free_cnt_reg  <= tcnt_t'(MAX_TAGS);
            bl_head_reg   <= '0;
            bl_cnt_reg    <= '0;
            active_reg    <= '0;
            written_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tcnt_reg      <= tcnt_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            bl_head_reg   <= bl_head_next;
            bl_cnt_reg    <= bl_cnt_next;
            active_reg    <= active_next;
            written_reg   <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req_type;
            handle_reg <= request_handle;
            ctag_reg   <= completion_tag;
        end
    end

endmodule

// ===== rtl/command_tag_allocator_with_backlog_core.sv =====
// Flow: an accepted item starts a registered read of the free-tag, request and backlog
// memories; the execute state resolves it and writes back once the output buffer has room,
// and the result is registered there before it is offered. The input stalls meanwhile, so a
// new item waits until the last is written back; a completion that hands its tag on holds two results.
// Reset (rst_n, async, active low): tag_count 64, free list 0..63, no active tags,
// empty backlog; ready at once, with no memory clearing pass.
`include "command_tag_allocator_with_backlog_core_macros.svh"

module command_tag_allocator_with_backlog_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [ctab_pkg::HANDLE_W-1:0]   request_handle,
    input  logic [ctab_pkg::CTAG_W-1:0]     completion_tag,
    input  logic                            cfg_wr_en,
    input  logic [ctab_pkg::TCNT_W-1:0]     cfg_wr_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ctab_pkg::KIND_W-1:0]     result_kind,
    output logic [ctab_pkg::TAG_W-1:0]      result_tag,
    output logic [ctab_pkg::HANDLE_W-1:0]   result_handle,
    output logic                            last
);

    import ctab_pkg::*;

    free_mem_req_t free_req;
    act_mem_req_t  act_req;
    bl_mem_req_t   bl_req;
    tag_t          free_rdata;
    handle_t       act_rdata;
    handle_t       bl_rdata;
    logic [1:0]    space;
    push_t         push;

    // Sequencer: issue the reads on accept, then resolve and write back in the execute state once the buffer has room
    ctab_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .request_handle (request_handle),
        .completion_tag (completion_tag),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .free_req       (free_req),
        .free_rdata     (free_rdata),
        .act_req        (act_req),
        .act_rdata      (act_rdata),
        .bl_req         (bl_req),
        .bl_rdata       (bl_rdata),
        .space          (space),
        .push           (push)
    );

    // Free-tag ring; slots not yet written since reinit read as their own index
    ctab_ram #(
        .WIDTH (TAG_W),
        .DEPTH (MAX_TAGS)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_req.we),
        .waddr (free_req.waddr),
        .wdata (free_req.wdata),
        .re    (free_req.re),
        .raddr (free_req.raddr),
        .rdata (free_rdata)
    );

    // Request handle held under each active tag
    ctab_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (MAX_TAGS)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_req.we),
        .waddr (act_req.waddr),
        .wdata (act_req.wdata),
        .re    (act_req.re),
        .raddr (act_req.raddr),
        .rdata (act_rdata)
    );

    // Backlog ring of waiting request handles
    ctab_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (BACKLOG_DEPTH)
    ) u_bl_ram (
        .clk   (clk),
        .we    (bl_req.we),
        .waddr (bl_req.waddr),
        .wdata (bl_req.wdata),
        .re    (bl_req.re),
        .raddr (bl_req.raddr),
        .rdata (bl_rdata)
    );

    // Two-entry output buffer; hold results while the sink stalls
    ctab_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .space         (space),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .result_tag    (result_tag),
        .result_handle (result_handle),
        .last          (last)
    );

    // A pair of results goes in only when both buffer slots are free, counting the item leaving
    `ASSERT_IMP(a_pair_fits, clk, rst_n, push.v1, push.v0 && space == 2'd2, "pair pushed without room")
    // A pair is a dispatch that is not last followed by a last result
    `ASSERT_IMP(a_pair_order, clk, rst_n, push.v1, push.r0.kind == KIND_DISPATCH && !push.r0.last && push.r1.last, "bad result pair")
    // An accepted item keeps the input side busy for the next cycle
    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken twice in a row")

endmodule
